// ----- rtl/hsbp_pkg.sv -----
`default_nettype none

package hsbp_pkg;

   // code store geometry
   localparam int SYMBOL_COUNT  = 256;
   localparam int SYM_AW        = $clog2(SYMBOL_COUNT);
   localparam int SYMBOL_BITS   = 8;
   localparam int MAX_CODE_BITS = 24;
   localparam int LEN_BITS      = 5;
   localparam int ENTRY_BITS    = LEN_BITS + MAX_CODE_BITS;

   // bit accumulator geometry
   localparam int ACC_BITS  = 32;
   localparam int BYTE_BITS = 8;
   localparam int PEND_BITS = 6;
   localparam int SUM_BITS  = 7;

   // request kinds
   typedef enum logic [1:0] {
      KIND_LOAD   = 2'd0,
      KIND_ENCODE = 2'd1,
      KIND_FLUSH  = 2'd2
   } kind_type;

   // one code store entry
   typedef struct packed {
      logic [LEN_BITS-1:0]      length;
      logic [MAX_CODE_BITS-1:0] bits;
   } code_entry_type;

endpackage

`default_nettype wire

// ----- rtl/hsbp_ram.sv -----
`default_nettype none

module hsbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/huffman_symbol_bit_packer_unit.sv -----
`default_nettype none

// Huffman symbol bit packer.
// Request channel (req_*): kind LOAD writes a (code, length) entry for a symbol,
// kind ENCODE appends the symbol's code MSB-first to a 32-bit accumulator,
// kind FLUSH drains every pending bit, zero-padding the last partial byte.
// Response channel (rsp_*): one packed byte per transaction; rsp_last marks the
// final byte caused by a request, rsp_bad_symbol flags an encode of a symbol
// with no loaded code (one response, byte zero).
// The response is registered: the code store is read at the accept edge, the
// packing stage forms each byte, then the output register holds it.
// A request holds the packing stage until it has emitted every byte it causes;
// the packing step emits one byte per cycle while the single output byte
// register can take it, and a new request is accepted in the cycle the stage
// finishes its current one.
// Reset clears the entry valid bits, the accumulator and pending count, and
// empties the pipeline; code store contents are not cleared (no clearing pass).
// While rsp_stall is high the output byte holds, the packing stage waits when
// it has a byte to emit and req_stall rises once it holds an unfinished request.
module huffman_symbol_bit_packer_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_kind,
   input  wire logic [7:0]  req_symbol,
   input  wire logic [23:0] req_code_value,
   input  wire logic [4:0]  req_code_length,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_bad_symbol,
   output logic             rsp_last
);

   // request side signals
   logic                                req_accept;
   logic                                req_in_range;
   logic [hsbp_pkg::SYM_AW-1:0]         req_index;
   logic [hsbp_pkg::LEN_BITS-1:0]       load_len;
   logic [hsbp_pkg::MAX_CODE_BITS:0]    load_mask;
   hsbp_pkg::code_entry_type            load_entry;
   logic                                ram_wr_en;
   logic                                ram_rd_en;
   logic [hsbp_pkg::ENTRY_BITS-1:0]     ram_rd_data;
   hsbp_pkg::code_entry_type            cur_entry;

   // entry valid bits
   logic [hsbp_pkg::SYMBOL_COUNT-1:0]   entry_valid_ff;
   logic [hsbp_pkg::SYMBOL_COUNT-1:0]   entry_valid_in;

   // packing stage
   logic                                stage_valid_ff;
   logic                                stage_valid_in;
   hsbp_pkg::kind_type                  stage_kind_ff;
   logic                                stage_hit_ff;
   logic                                stage_done;

   // accumulator state
   logic [hsbp_pkg::ACC_BITS-1:0]       acc_ff;
   logic [hsbp_pkg::ACC_BITS-1:0]       acc_in;
   logic [hsbp_pkg::PEND_BITS-1:0]      pend_ff;
   logic [hsbp_pkg::PEND_BITS-1:0]      pend_in;

   // datapath helpers
   logic [hsbp_pkg::SUM_BITS-1:0]       sum_now;
   logic [hsbp_pkg::SUM_BITS-1:0]       sum_after;
   logic                                overflow;
   logic                                fits_after;
   logic [hsbp_pkg::ACC_BITS-1:0]       acc_appended;
   logic [hsbp_pkg::ACC_BITS-1:0]       top_shift;
   logic [hsbp_pkg::BYTE_BITS-1:0]      top_byte;
   logic [hsbp_pkg::BYTE_BITS-1:0]      part_byte;

   // output register
   logic                                can_emit;
   logic                                emit;
   logic [hsbp_pkg::BYTE_BITS-1:0]      emit_byte;
   logic                                emit_bad;
   logic                                emit_last;
   logic                                rsp_valid_ff;
   logic                                rsp_valid_in;
   logic [hsbp_pkg::BYTE_BITS-1:0]      rsp_byte_ff;
   logic                                rsp_bad_ff;
   logic                                rsp_last_ff;

   // request handshake
   assign req_stall  = stage_valid_ff && !stage_done;
   assign req_accept = req_valid && !req_stall;

   assign req_in_range = ({1'b0, req_symbol} < (hsbp_pkg::SYMBOL_BITS + 1)'(hsbp_pkg::SYMBOL_COUNT));
   assign req_index    = req_symbol[hsbp_pkg::SYM_AW-1:0];

   // load entry: clamp length, mask code
   always_comb begin
      if (req_code_length > hsbp_pkg::LEN_BITS'(hsbp_pkg::MAX_CODE_BITS)) begin
         load_len = hsbp_pkg::LEN_BITS'(hsbp_pkg::MAX_CODE_BITS);
      end else begin
         load_len = req_code_length;
      end
      load_mask         = ((hsbp_pkg::MAX_CODE_BITS + 1)'(1) << load_len)
                          - (hsbp_pkg::MAX_CODE_BITS + 1)'(1);
      load_entry.length = load_len;
      load_entry.bits   = req_code_value & load_mask[hsbp_pkg::MAX_CODE_BITS-1:0];
   end

   assign ram_wr_en = req_accept && (req_kind == hsbp_pkg::KIND_LOAD) && req_in_range;
   assign ram_rd_en = req_accept && (req_kind == hsbp_pkg::KIND_ENCODE);

   // code store
   hsbp_ram #(
      .WIDTH (hsbp_pkg::ENTRY_BITS),
      .DEPTH (hsbp_pkg::SYMBOL_COUNT)
   ) u_code_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (req_index),
      .wr_data (load_entry),
      .rd_en   (ram_rd_en),
      .rd_addr (req_index),
      .rd_data (ram_rd_data)
   );

   assign cur_entry = hsbp_pkg::code_entry_type'(ram_rd_data);

   // valid bits next value
   always_comb begin
      entry_valid_in = entry_valid_ff;
      if (ram_wr_en) begin
         entry_valid_in[req_index] = 1'b1;
      end
   end

   // stage occupancy
   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (req_accept) begin
         stage_valid_in = 1'b1;
      end else if (stage_done) begin
         stage_valid_in = 1'b0;
      end
   end

   // bit arithmetic
   assign sum_now      = {1'b0, pend_ff} + {2'b00, cur_entry.length};
   assign overflow     = sum_now > hsbp_pkg::SUM_BITS'(hsbp_pkg::ACC_BITS);
   assign sum_after    = sum_now - hsbp_pkg::SUM_BITS'(hsbp_pkg::BYTE_BITS);
   assign fits_after   = sum_after <= hsbp_pkg::SUM_BITS'(hsbp_pkg::ACC_BITS);
   assign acc_appended = (acc_ff << cur_entry.length)
                         | {{(hsbp_pkg::ACC_BITS - hsbp_pkg::MAX_CODE_BITS){1'b0}},
                            cur_entry.bits};
   assign top_shift    = acc_ff >> (pend_ff - hsbp_pkg::PEND_BITS'(hsbp_pkg::BYTE_BITS));
   assign top_byte     = top_shift[hsbp_pkg::BYTE_BITS-1:0];
   assign part_byte    = acc_ff[hsbp_pkg::BYTE_BITS-1:0] << (4'd8 - pend_ff[3:0]);

   assign can_emit = !rsp_valid_ff || !rsp_stall;

   // packing step
   always_comb begin
      stage_done = 1'b0;
      emit       = 1'b0;
      emit_byte  = '0;
      emit_bad   = 1'b0;
      emit_last  = 1'b0;
      acc_in     = acc_ff;
      pend_in    = pend_ff;
      if (stage_valid_ff) begin
         case (stage_kind_ff)
            hsbp_pkg::KIND_ENCODE: begin
               if (!stage_hit_ff) begin
                  // symbol without a code
                  if (can_emit) begin
                     emit       = 1'b1;
                     emit_bad   = 1'b1;
                     emit_last  = 1'b1;
                     stage_done = 1'b1;
                  end
               end else if (overflow) begin
                  // drain one byte from the top before appending
                  if (can_emit) begin
                     emit      = 1'b1;
                     emit_byte = top_byte;
                     if (fits_after) begin
                        emit_last  = 1'b1;
                        stage_done = 1'b1;
                        acc_in     = acc_appended;
                        pend_in    = sum_after[hsbp_pkg::PEND_BITS-1:0];
                     end else begin
                        pend_in = pend_ff - hsbp_pkg::PEND_BITS'(hsbp_pkg::BYTE_BITS);
                     end
                  end
               end else begin
                  stage_done = 1'b1;
                  acc_in     = acc_appended;
                  pend_in    = sum_now[hsbp_pkg::PEND_BITS-1:0];
               end
            end
            hsbp_pkg::KIND_FLUSH: begin
               if (pend_ff == '0) begin
                  stage_done = 1'b1;
                  acc_in     = '0;
               end else if (can_emit) begin
                  emit = 1'b1;
                  if (pend_ff >= hsbp_pkg::PEND_BITS'(hsbp_pkg::BYTE_BITS)) begin
                     emit_byte = top_byte;
                     pend_in   = pend_ff - hsbp_pkg::PEND_BITS'(hsbp_pkg::BYTE_BITS);
                  end else begin
                     emit_byte = part_byte;
                     pend_in   = '0;
                  end
                  if (pend_in == '0) begin
                     emit_last  = 1'b1;
                     stage_done = 1'b1;
                     acc_in     = '0;
                  end
               end
            end
            default: begin
               // loads finish at the store write, unused kind is dropped
               stage_done = 1'b1;
            end
         endcase
      end
   end

   // output register occupancy
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
         stage_valid_ff <= 1'b0;
         acc_ff         <= '0;
         pend_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         entry_valid_ff <= entry_valid_in;
         stage_valid_ff <= stage_valid_in;
         acc_ff         <= acc_in;
         pend_ff        <= pend_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         stage_kind_ff <= hsbp_pkg::kind_type'(req_kind);
         stage_hit_ff  <= req_in_range && entry_valid_ff[req_index];
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_byte_ff <= emit_byte;
         rsp_bad_ff  <= emit_bad;
         rsp_last_ff <= emit_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = rsp_byte_ff;
   assign rsp_bad_symbol = rsp_bad_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

`default_nettype wire

// ----- sim/huffman_symbol_bit_packer_checker.sv -----
module huffman_symbol_bit_packer_checker
   import hsbp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_symbol,
   input  logic [23:0] req_code_value,
   input  logic [4:0]  req_code_length,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [7:0]  rsp_out_byte,
   input  logic        rsp_bad_symbol,
   input  logic        rsp_last,
   output int          results_waiting,
   output int          mismatch_count
);

   // one packed byte as the block should emit it
   typedef struct packed {
      logic [BYTE_BITS-1:0] out_byte;
      logic                 bad_symbol;
      logic                 last;
   } coded_byte_type;

   localparam int PRINT_CAP = 100;

   // shadow of the code table and the bit accumulator
   code_entry_type       code_table [SYMBOL_COUNT];
   logic                 entry_loaded [SYMBOL_COUNT];
   logic [ACC_BITS-1:0]  packed_acc;
   logic [PEND_BITS-1:0] held_bits;
   coded_byte_type       expected_bytes [$];

   task automatic flag_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP)
         $display("mismatch at %0t: %s", $time, msg);
   endtask

   task automatic queue_byte(input logic [BYTE_BITS-1:0] value, input logic bad);
      coded_byte_type item;
      item.out_byte   = value;
      item.bad_symbol = bad;
      item.last       = 1'b0;
      expected_bytes.push_back(item);
   endtask

   // the newest expected byte closes this transaction
   task automatic mark_last();
      expected_bytes[expected_bytes.size()-1].last = 1'b1;
   endtask

   function automatic logic [BYTE_BITS-1:0] leading_byte();
      return 8'(packed_acc >> (held_bits - PEND_BITS'(BYTE_BITS)));
   endfunction

   // work out the bytes caused by one accepted request
   task automatic predict_packing(input logic [1:0] kind, input logic [7:0] sym,
                                  input logic [23:0] val, input logic [4:0] len);
      logic [LEN_BITS-1:0] len_sat;
      logic [31:0]         keep_mask;
      code_entry_type      entry;
      int                  emitted;
      emitted = 0;
      case (kind_type'(kind))
         KIND_LOAD: begin
            if (int'(sym) < SYMBOL_COUNT) begin
               len_sat = (int'(len) > MAX_CODE_BITS) ? LEN_BITS'(MAX_CODE_BITS) : len;
               keep_mask = (32'd1 << len_sat) - 32'd1;
               code_table[sym].length = len_sat;
               code_table[sym].bits   = val & keep_mask[MAX_CODE_BITS-1:0];
               entry_loaded[sym]      = 1'b1;
            end
         end
         KIND_ENCODE: begin
            if (int'(sym) >= SYMBOL_COUNT || !entry_loaded[sym]) begin
               // no code for this byte: one flagged zero byte, state untouched
               queue_byte('0, 1'b1);
               mark_last();
            end else begin
               entry = code_table[sym];
               while (int'(held_bits) + int'(entry.length) > ACC_BITS) begin
                  queue_byte(leading_byte(), 1'b0);
                  held_bits = held_bits - PEND_BITS'(BYTE_BITS);
                  emitted++;
               end
               if (entry.length != '0) begin
                  packed_acc = (packed_acc << entry.length) | ACC_BITS'(entry.bits);
                  held_bits  = held_bits + PEND_BITS'(entry.length);
               end
               if (emitted > 0)
                  mark_last();
            end
         end
         KIND_FLUSH: begin
            // drain whole bytes, then the zero-padded partial byte
            while (held_bits != '0) begin
               if (int'(held_bits) >= BYTE_BITS) begin
                  queue_byte(leading_byte(), 1'b0);
                  held_bits = held_bits - PEND_BITS'(BYTE_BITS);
               end else begin
                  queue_byte(8'(packed_acc << (BYTE_BITS - int'(held_bits))), 1'b0);
                  held_bits = '0;
               end
               emitted++;
            end
            packed_acc = '0;
            held_bits  = '0;
            if (emitted > 0)
               mark_last();
         end
         default: begin
            // unused kind is dropped
         end
      endcase
   endtask

   // compare one accepted byte with the oldest expectation
   task automatic check_byte();
      coded_byte_type want;
      if (expected_bytes.size() == 0) begin
         flag_mismatch($sformatf("unexpected byte %02h bad %0b last %0b",
                                 rsp_out_byte, rsp_bad_symbol, rsp_last));
      end else begin
         want = expected_bytes.pop_front();
         if (rsp_out_byte !== want.out_byte)
            flag_mismatch($sformatf("out_byte %02h, expected %02h",
                                    rsp_out_byte, want.out_byte));
         if (rsp_bad_symbol !== want.bad_symbol)
            flag_mismatch($sformatf("bad_symbol %0b, expected %0b",
                                    rsp_bad_symbol, want.bad_symbol));
         if (rsp_last !== want.last)
            flag_mismatch($sformatf("last %0b, expected %0b", rsp_last, want.last));
      end
   endtask

   // watch both channels at each edge
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SYMBOL_COUNT; i++)
            entry_loaded[i] = 1'b0;
         packed_acc = '0;
         held_bits  = '0;
         expected_bytes.delete();
      end else begin
         if (req_valid && !req_stall)
            predict_packing(req_kind, req_symbol, req_code_value, req_code_length);
         if (rsp_valid && !rsp_stall)
            check_byte();
      end
      results_waiting = expected_bytes.size();
   end

endmodule

// ----- sim/tb_huffman_symbol_bit_packer_unit.sv -----
module tb_huffman_symbol_bit_packer_unit;
   import hsbp_pkg::*;

   localparam int          RANDOM_ITEMS   = 425;
   localparam int          IDLE_LIMIT     = 600;
   localparam int          TAIL_CYCLES    = 16;
   localparam logic [1:0]  KIND_UNUSED    = 2'd3;
   localparam logic [3:0]  NO_CODE_NIBBLE = 4'hD;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_kind;
   logic [7:0]  req_symbol;
   logic [23:0] req_code_value;
   logic [4:0]  req_code_length;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_out_byte;
   logic        rsp_bad_symbol;
   logic        rsp_last;

   int          results_waiting;
   int          mismatch_count;

   // sender bookkeeping
   int          burst_left = 0;
   logic [255:0] sym_loaded = '0;
   logic [7:0]  loaded_syms [$];

   // receiver stall pattern state
   stall_mode_type stall_mode = STALL_NONE;
   int          stall_mode_left = 0;
   int          stall_phase = 0;

   int          idle_cycles = 0;

   huffman_symbol_bit_packer_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_symbol      (req_symbol),
      .req_code_value  (req_code_value),
      .req_code_length (req_code_length),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_bad_symbol  (rsp_bad_symbol),
      .rsp_last        (rsp_last)
   );

   huffman_symbol_bit_packer_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_symbol      (req_symbol),
      .req_code_value  (req_code_value),
      .req_code_length (req_code_length),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_bad_symbol  (rsp_bad_symbol),
      .rsp_last        (rsp_last),
      .results_waiting (results_waiting),
      .mismatch_count  (mismatch_count)
   );

   always #4 clock = ~clock;

   // one request transaction, with burst gaps in front of it
   task automatic send_item(input logic [1:0] kind, input logic [7:0] sym,
                            input logic [23:0] val, input logic [4:0] len);
      int roll;
      int idle_gap;
      if (burst_left == 0) begin
         roll = $urandom_range(0, 99);
         if (roll < 50)      idle_gap = 0;
         else if (roll < 85) idle_gap = $urandom_range(1, 3);
         else if (roll < 97) idle_gap = $urandom_range(4, 12);
         else                idle_gap = $urandom_range(20, 40);
         if (idle_gap > 0) begin
            req_valid <= 1'b0;
            repeat (idle_gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120)
                                                  : $urandom_range(1, 24);
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_kind        <= kind;
      req_symbol      <= sym;
      req_code_value  <= val;
      req_code_length <= len;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic load_code(input logic [7:0] sym, input logic [23:0] val,
                            input logic [4:0] len);
      send_item(KIND_LOAD, sym, val, len);
      if (!sym_loaded[sym]) begin
         sym_loaded[sym] = 1'b1;
         loaded_syms.push_back(sym);
      end
   endtask

   // the unused fields carry noise on encode and flush
   task automatic encode_sym(input logic [7:0] sym);
      send_item(KIND_ENCODE, sym, 24'($urandom), 5'($urandom));
   endtask

   task automatic flush_stream();
      send_item(KIND_FLUSH, 8'($urandom), 24'($urandom), 5'($urandom));
   endtask

   // hold the sender until every expected byte has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (results_waiting != 0) @(posedge clock);
   endtask

   // stimulus
   initial begin
      int         coded_items;
      int         roll;
      bit         paused;
      logic [7:0] sym;
      logic [4:0] len;
      coded_items = 0;
      paused      = 1'b0;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_kind        <= KIND_LOAD;
      req_symbol      <= '0;
      req_code_value  <= '0;
      req_code_length <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, empty flush, unused kind
      encode_sym(8'h00);
      flush_stream();
      send_item(KIND_UNUSED, 8'hFF, 24'hFFFFFF, 5'h1F);
      // directed: table extremes, masking, saturation, zero length
      load_code(8'h00, 24'hFFFFFF, 5'd1);
      load_code(8'hFF, 24'hFFFFFF, 5'd24);
      load_code(8'h55, 24'hABCDEF, 5'd31);
      load_code(8'hAA, 24'h123456, 5'd0);
      load_code(8'h12, 24'h00005A, 5'd7);
      load_code(8'h20, 24'h0000C3, 5'd8);
      encode_sym(8'hAA);
      flush_stream();
      // directed: three-byte encode, missing code mid-stream, partial flush
      encode_sym(8'h00);
      encode_sym(8'hFF);
      encode_sym(8'hFF);
      encode_sym(8'hD3);
      encode_sym(8'h55);
      encode_sym(8'h12);
      flush_stream();
      // directed: exactly full accumulator, then a 24-bit code on top
      repeat (4) encode_sym(8'h20);
      encode_sym(8'hFF);
      flush_stream();
      encode_sym(8'h00);
      flush_stream();
      drain_results();

      // random: mostly code streams closed by a flush
      while (coded_items < RANDOM_ITEMS) begin
         if (!paused && coded_items == RANDOM_ITEMS / 2) begin
            drain_results();
            paused = 1'b1;
         end
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            sym = 8'($urandom);
            if (sym[7:4] == NO_CODE_NIBBLE)
               sym[7] = 1'b0;
            roll = $urandom_range(0, 99);
            if (roll < 70)      len = 5'($urandom_range(1, 24));
            else if (roll < 85) len = 5'($urandom_range(1, 4));
            else if (roll < 95) len = 5'($urandom_range(25, 31));
            else                len = '0;
            load_code(sym, 24'($urandom), len);
            coded_items++;
         end else if (roll < 12) begin
            encode_sym({NO_CODE_NIBBLE, 4'($urandom)});
            coded_items++;
         end else if (roll < 15) begin
            send_item(KIND_UNUSED, 8'($urandom), 24'($urandom), 5'($urandom));
         end else if (roll < 25) begin
            flush_stream();
            coded_items++;
         end else begin
            encode_sym(loaded_syms[$urandom_range(0, loaded_syms.size() - 1)]);
            coded_items++;
         end
      end
      flush_stream();

      // wait out the last bytes and a quiet tail
      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // receiver stall pattern, switching mode at random
   initial rsp_stall <= 1'b0;
   always @(posedge clock) begin
      stall_phase <= (stall_phase + 1) % 7;
      if (stall_mode_left == 0) begin
         stall_mode      <= stall_mode_type'($urandom_range(0, 3));
         stall_mode_left <= $urandom_range(16, 96);
      end else begin
         stall_mode_left <= stall_mode_left - 1;
      end
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:     rsp_stall <= (stall_phase < 3);
      endcase
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

// ----- huffman_symbol_bit_packer_unit.f -----
rtl/hsbp_pkg.sv
rtl/hsbp_ram.sv
rtl/huffman_symbol_bit_packer_unit.sv
sim/huffman_symbol_bit_packer_checker.sv
sim/tb_huffman_symbol_bit_packer_unit.sv
